// ----- rtl/core/flfa_pkg.sv -----
// flfa_pkg: types, codes and helpers shared by the chunk allocator modules
// no dependencies
`default_nettype none

package flfa_pkg;

  localparam int unsigned POOL_CHUNKS = 1024;
  localparam int unsigned IDX_W       = $clog2(POOL_CHUNKS);
  localparam int unsigned CNT_W       = IDX_W + 1;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned AMOUNT_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EXPAND = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_EXPAND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_CNT  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_NO_CHUNK  = 3'd2,
    ST_ZERO_EXP  = 3'd3,
    ST_BAD_FREE  = 3'd4
  } status_e;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [AMOUNT_W-1:0] request_amount;
    logic [IDX_W-1:0]    chunk_index;
  } item_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] granted_index;
    logic [CNT_W-1:0] in_use_count;
    logic [CNT_W-1:0] capacity_now;
    logic             capacity_clipped;
  } result_t;

  typedef struct packed {
    logic [AMOUNT_W-1:0] chunk_bytes;
    logic [CNT_W-1:0]    auto_expand_count;
    logic [CNT_W-1:0]    initial_count;
  } cfg_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } link_req_t;

  // capacity = min(initial + extra, pool size)
  function automatic logic [CNT_W-1:0] capacity_of(input logic [CNT_W-1:0] init,
                                                   input logic [CNT_W-1:0] extra);
    logic [CNT_W:0] sum;
    sum = {1'b0, init} + {1'b0, extra};
    if (sum > (CNT_W+1)'(POOL_CHUNKS)) begin
      return CNT_W'(POOL_CHUNKS);
    end
    return sum[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/flfa_cfg_regs.sv -----
// flfa_cfg_regs: configuration registers of the chunk allocator
// depends on flfa_pkg
`default_nettype none

module flfa_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [flfa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [flfa_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output flfa_pkg::cfg_t                     cfg_o
);

  flfa_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        flfa_pkg::CFG_CHUNK_BYTES: cfg_d.chunk_bytes = cfg_data_i;
        flfa_pkg::CFG_AUTO_EXPAND: cfg_d.auto_expand_count = cfg_data_i[flfa_pkg::CNT_W-1:0];
        flfa_pkg::CFG_INITIAL_CNT: cfg_d.initial_count = cfg_data_i[flfa_pkg::CNT_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chunk_bytes       <= flfa_pkg::AMOUNT_W'(64);
      cfg_q.auto_expand_count <= '0;
      cfg_q.initial_count     <= flfa_pkg::CNT_W'(flfa_pkg::POOL_CHUNKS);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/core/flfa_link_mem.sv -----
// flfa_link_mem: next-link store of the free list, one write and one registered read port
// depends on flfa_pkg
`default_nettype none

module flfa_link_mem (
  input  logic                          clk_i,
  input  flfa_pkg::link_req_t           req_i,
  output logic [flfa_pkg::IDX_W-1:0]    rd_data_o
);

  logic [flfa_pkg::IDX_W-1:0] mem [flfa_pkg::POOL_CHUNKS];
  logic [flfa_pkg::IDX_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

// ----- rtl/core/flfa_engine.sv -----
// flfa_engine: allocator state and the single-pass alloc / free / expand logic
// depends on flfa_pkg; drives flfa_link_mem through a link_req_t
`default_nettype none

module flfa_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  flfa_pkg::item_t               item_i,
  input  flfa_pkg::cfg_t                cfg_i,
  input  logic [flfa_pkg::IDX_W-1:0]    rd_data_i,
  output flfa_pkg::link_req_t           mem_req_o,
  output flfa_pkg::result_t             result_o
);

  localparam int unsigned GROW_W = flfa_pkg::AMOUNT_W + 1;

  logic [flfa_pkg::IDX_W-1:0] head_q, head_d;
  logic [flfa_pkg::IDX_W-1:0] head_next_q, head_next_d;
  logic                       from_mem_q, from_mem_d;
  logic                       nonempty_q, nonempty_d;
  logic [flfa_pkg::CNT_W-1:0] fresh_q, fresh_d;
  logic [flfa_pkg::CNT_W-1:0] extra_q, extra_d;
  logic [flfa_pkg::CNT_W-1:0] in_use_q, in_use_d;

  logic [flfa_pkg::IDX_W-1:0] head_next;
  logic [GROW_W-1:0]          grow_amt;
  logic [GROW_W-1:0]          grow_sum;
  logic                       grow_clip;
  logic [flfa_pkg::CNT_W-1:0] grow_extra;
  logic [flfa_pkg::CNT_W-1:0] cap_now;

  // link of the current head: straight from the memory after a list pop
  assign head_next = from_mem_q ? rd_data_i : head_next_q;

  // one shared saturating adder for auto-expand and explicit expand
  assign grow_amt   = (item_i.func == flfa_pkg::FUNC_ALLOC) ? GROW_W'(cfg_i.auto_expand_count)
                                                            : GROW_W'(item_i.request_amount);
  assign grow_sum   = GROW_W'(extra_q) + grow_amt;
  assign grow_clip  = ((GROW_W+1)'(cfg_i.initial_count) + (GROW_W+1)'(grow_sum))
                      > (GROW_W+1)'(flfa_pkg::POOL_CHUNKS);
  assign grow_extra = (grow_sum > GROW_W'(flfa_pkg::POOL_CHUNKS))
                      ? flfa_pkg::CNT_W'(flfa_pkg::POOL_CHUNKS) : grow_sum[flfa_pkg::CNT_W-1:0];
  assign cap_now    = flfa_pkg::capacity_of(cfg_i.initial_count, extra_q);

  always_comb begin
    head_d      = head_q;
    head_next_d = head_next_q;
    from_mem_d  = from_mem_q;
    nonempty_d  = nonempty_q;
    fresh_d     = fresh_q;
    extra_d     = extra_q;
    in_use_d    = in_use_q;
    mem_req_o   = '0;
    result_o.status           = flfa_pkg::ST_OK;
    result_o.granted_index    = '0;
    result_o.capacity_clipped = 1'b0;

    if (fire_i) begin
      unique case (item_i.func)
        flfa_pkg::FUNC_ALLOC: begin
          if (item_i.request_amount > cfg_i.chunk_bytes) begin
            result_o.status = flfa_pkg::ST_TOO_LARGE;
          end else if (nonempty_q) begin
            result_o.granted_index = head_q;
            head_d     = head_next;
            in_use_d   = in_use_q + flfa_pkg::CNT_W'(1);
            nonempty_d = fresh_q > in_use_d;
            // fetch the link of the new head for the next pop
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = head_next;
            from_mem_d = 1'b1;
          end else begin
            if ((fresh_q >= cap_now) && (cfg_i.auto_expand_count != '0)) begin
              extra_d = grow_extra;
              result_o.capacity_clipped = grow_clip;
            end
            if (fresh_q < flfa_pkg::capacity_of(cfg_i.initial_count, extra_d)) begin
              result_o.granted_index = fresh_q[flfa_pkg::IDX_W-1:0];
              fresh_d  = fresh_q + flfa_pkg::CNT_W'(1);
              in_use_d = in_use_q + flfa_pkg::CNT_W'(1);
            end else begin
              result_o.status = flfa_pkg::ST_NO_CHUNK;
            end
          end
        end
        flfa_pkg::FUNC_FREE: begin
          if ((in_use_q == '0) || ({1'b0, item_i.chunk_index} >= fresh_q)) begin
            result_o.status = flfa_pkg::ST_BAD_FREE;
          end else begin
            mem_req_o.wr_en   = 1'b1;
            mem_req_o.wr_addr = item_i.chunk_index;
            mem_req_o.wr_data = head_q;
            head_d      = item_i.chunk_index;
            head_next_d = head_q;
            from_mem_d  = 1'b0;
            nonempty_d  = 1'b1;
            in_use_d    = in_use_q - flfa_pkg::CNT_W'(1);
          end
        end
        flfa_pkg::FUNC_EXPAND: begin
          if (item_i.request_amount == '0) begin
            result_o.status = flfa_pkg::ST_ZERO_EXP;
          end else begin
            extra_d = grow_extra;
            result_o.capacity_clipped = grow_clip;
          end
        end
        default: begin
          // unused function code: report current counts only
          result_o.status = flfa_pkg::ST_OK;
        end
      endcase
    end

    result_o.in_use_count = in_use_d;
    result_o.capacity_now = flfa_pkg::capacity_of(cfg_i.initial_count, extra_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      head_next_q <= '0;
      from_mem_q  <= 1'b0;
      nonempty_q  <= 1'b0;
      fresh_q     <= '0;
      extra_q     <= '0;
      in_use_q    <= '0;
    end else begin
      head_q      <= head_d;
      head_next_q <= head_next_d;
      from_mem_q  <= from_mem_d;
      nonempty_q  <= nonempty_d;
      fresh_q     <= fresh_d;
      extra_q     <= extra_d;
      in_use_q    <= in_use_d;
    end
  end

`ifndef SYNTHESIS
  a_in_use_le_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_use_q <= fresh_q)
    else $error("more chunks in use than ever handed out");

  a_list_matches_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nonempty_q == (fresh_q > in_use_q))
    else $error("free list flag disagrees with counts");

  a_fresh_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fresh_q <= flfa_pkg::CNT_W'(flfa_pkg::POOL_CHUNKS))
    && (extra_q <= flfa_pkg::CNT_W'(flfa_pkg::POOL_CHUNKS)))
    else $error("counter beyond pool size");

  a_pop_fetches_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (item_i.func == flfa_pkg::FUNC_ALLOC) && nonempty_q
     && (item_i.request_amount <= cfg_i.chunk_bytes)) |=> from_mem_q)
    else $error("list pop did not switch link source to memory");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/fixed_chunk_free_list_allocator.sv -----
// Fixed-size chunk allocator over a pool of 1024 chunks named by index. Each request is an
// alloc, a free or an expand and gives exactly one result. A request is registered on entry,
// worked against the allocator state and registered again on exit. One request can be taken
// every cycle while the result register is free to advance; the free-list link memory has a
// registered read that is issued by a pop and used directly by the following request. No
// clearing pass is needed after reset. Configuration is taken whenever offered (cfg_ready_o
// is always high) and must only be written while the block is idle.
// depends on flfa_pkg, flfa_cfg_regs, flfa_link_mem, flfa_engine
`default_nettype none

module fixed_chunk_free_list_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  flfa_pkg::item_t                 in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output flfa_pkg::result_t               out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [flfa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [flfa_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  flfa_pkg::cfg_t      cfg;
  flfa_pkg::link_req_t mem_req;
  flfa_pkg::result_t   result;
  logic [flfa_pkg::IDX_W-1:0] rd_data;

  flfa_pkg::item_t   in_q;
  logic              in_vld_q, in_vld_d;
  flfa_pkg::result_t res_q;
  logic              res_vld_q, res_vld_d;
  logic              advance;
  logic              fire;
  logic              accept;

  // result stage frees up when empty or when its result is taken
  assign advance    = !res_vld_q || !out_stall_i;
  assign fire       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_vld_d  = accept || (in_vld_q && !fire);
  assign res_vld_d = fire || (res_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      res_q <= result;
    end
  end

  flfa_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  flfa_link_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  flfa_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .rd_data_i (rd_data),
    .mem_req_o (mem_req),
    .result_o  (result)
  );

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// tb: self-checking bench for the fixed chunk allocator; a directed request table, then
// random phases under varied configuration and handshake idling, checked by a shadow model
// depends on flfa_pkg and fixed_chunk_free_list_allocator
`timescale 1ns / 100ps

module tb;
  import flfa_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef enum bit {ROW_REQUEST, ROW_CONFIG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    item_t       req;
    bit          typed;
    result_t     known;
    int unsigned cb;
    int unsigned ae;
    int unsigned ic;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  item_t                 in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  result_t               out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  fixed_chunk_free_list_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // shadow of the allocator state and its registers
  logic [IDX_W-1:0] link_shadow [POOL_CHUNKS];
  logic [IDX_W-1:0] free_top = '0;
  bit               free_live = 1'b0;
  int unsigned      fresh_issued = 0;
  int unsigned      extra_grant = 0;
  int unsigned      live_chunks = 0;
  int unsigned      chunk_limit = 64;
  int unsigned      auto_step = 0;
  int unsigned      base_count = 1024;

  result_t     awaited_results [$];
  int unsigned held_chunks [$];
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_order = 0;
  int unsigned hold_left = 0;
  int unsigned fail_count = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned grant_count = 0;
  int unsigned starved_count = 0;
  int unsigned clipped_count = 0;
  int unsigned bad_free_count = 0;

  function automatic int unsigned pool_capacity();
    int unsigned sum;
    sum = base_count + extra_grant;
    return (sum > POOL_CHUNKS) ? POOL_CHUNKS : sum;
  endfunction

  // saturating growth of the extra capacity; flags a clip at the pool size
  function automatic bit grow_capacity(input int unsigned amount);
    int unsigned sum;
    bit          clip;
    sum = extra_grant + amount;
    clip = (base_count + sum > POOL_CHUNKS);
    extra_grant = (sum > POOL_CHUNKS) ? POOL_CHUNKS : sum;
    return clip;
  endfunction

  function automatic result_t predict_outcome(input item_t req);
    result_t r;
    r = '0;
    r.status = ST_OK;
    case (req.func)
      FUNC_ALLOC: begin
        if (req.request_amount > chunk_limit) begin
          r.status = ST_TOO_LARGE;
        end else if (free_live) begin
          r.granted_index = free_top;
          free_top = link_shadow[free_top];
          live_chunks++;
          free_live = fresh_issued > live_chunks;
        end else begin
          if (fresh_issued >= pool_capacity() && auto_step != 0) begin
            r.capacity_clipped = grow_capacity(auto_step);
          end
          if (fresh_issued < pool_capacity()) begin
            r.granted_index = fresh_issued[IDX_W-1:0];
            fresh_issued++;
            live_chunks++;
          end else begin
            r.status = ST_NO_CHUNK;
          end
        end
      end
      FUNC_FREE: begin
        if (live_chunks == 0 || req.chunk_index >= fresh_issued) begin
          r.status = ST_BAD_FREE;
        end else begin
          link_shadow[req.chunk_index] = free_top;
          free_top = req.chunk_index;
          free_live = 1'b1;
          live_chunks--;
        end
      end
      FUNC_EXPAND: begin
        if (req.request_amount == 0) begin
          r.status = ST_ZERO_EXP;
        end else begin
          r.capacity_clipped = grow_capacity(req.request_amount);
        end
      end
      default: begin
      end
    endcase
    r.in_use_count = live_chunks[CNT_W-1:0];
    r.capacity_now = CNT_W'(pool_capacity());
    return r;
  endfunction

  function automatic row_t req_row(input logic [FUNC_W-1:0] func, input int unsigned amt,
                                   input int unsigned idx);
    row_t row;
    row = '{kind: ROW_REQUEST, default: 0};
    row.req.func = func;
    row.req.request_amount = amt[AMOUNT_W-1:0];
    row.req.chunk_index = idx[IDX_W-1:0];
    return row;
  endfunction

  function automatic row_t typed_row(input logic [FUNC_W-1:0] func, input int unsigned amt,
                                     input int unsigned idx, input status_e st,
                                     input int unsigned granted, input int unsigned in_use,
                                     input int unsigned cap, input bit clip);
    row_t row;
    row = req_row(func, amt, idx);
    row.typed = 1'b1;
    row.known.status = st;
    row.known.granted_index = granted[IDX_W-1:0];
    row.known.in_use_count = in_use[CNT_W-1:0];
    row.known.capacity_now = cap[CNT_W-1:0];
    row.known.capacity_clipped = clip;
    return row;
  endfunction

  function automatic row_t cfg_row(input int unsigned cb, input int unsigned ae,
                                   input int unsigned ic);
    row_t row;
    row = '{kind: ROW_CONFIG, default: 0};
    row.cb = cb;
    row.ae = ae;
    row.ic = ic;
    return row;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_index_i <= idx;
    cfg_data_i <= data[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CHUNK_BYTES: chunk_limit = data & 16'hFFFF;
      CFG_AUTO_EXPAND: auto_step = data & 11'h7FF;
      CFG_INITIAL_CNT: base_count = data & 11'h7FF;
      default: begin
      end
    endcase
  endtask

  // only reprogram once every outstanding result has drained
  task automatic program_cfg(input int unsigned cb, input int unsigned ae,
                             input int unsigned ic);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    write_reg(CFG_CHUNK_BYTES, cb);
    write_reg(CFG_AUTO_EXPAND, ae);
    write_reg(CFG_INITIAL_CNT, ic);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_request(input item_t req, input bit typed, input result_t known);
    result_t p;
    int      hits [$];
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    p = predict_outcome(req);
    awaited_results.push_back(typed ? known : p);
    sent_count++;
    if (p.capacity_clipped) clipped_count++;
    if (p.status == ST_NO_CHUNK) starved_count++;
    if (p.status == ST_BAD_FREE) bad_free_count++;
    if (req.func == FUNC_ALLOC && p.status == ST_OK) begin
      held_chunks.push_back(p.granted_index);
      grant_count++;
    end
    if (req.func == FUNC_FREE && p.status == ST_OK) begin
      hits = held_chunks.find_first_index(x) with (x == req.chunk_index);
      if (hits.size() != 0) held_chunks.delete(hits[0]);
    end
  endtask

  function automatic item_t random_request(input int unsigned alloc_pct, input bit wide_expand);
    item_t       q;
    int unsigned pick;
    int unsigned sel;
    q.func = FUNC_UNUSED;
    q.request_amount = AMOUNT_W'($urandom_range(65535));
    q.chunk_index = IDX_W'($urandom_range(1023));
    pick = $urandom_range(99);
    if (pick < alloc_pct) begin
      q.func = FUNC_ALLOC;
      if ($urandom_range(4) != 0) q.request_amount = AMOUNT_W'($urandom_range(chunk_limit));
    end else if (pick < 92) begin
      q.func = FUNC_FREE;
      sel = $urandom_range(9);
      // mostly return a chunk we hold; some frees of any issued index catch double frees
      if (sel < 7 && held_chunks.size() != 0) begin
        q.chunk_index = IDX_W'(held_chunks[$urandom_range(held_chunks.size() - 1)]);
      end else if (sel < 9 && fresh_issued != 0) begin
        q.chunk_index = IDX_W'($urandom_range(fresh_issued - 1));
      end
    end else if (pick < 97) begin
      q.func = FUNC_EXPAND;
      if (!wide_expand || $urandom_range(1) == 0) begin
        q.request_amount = AMOUNT_W'($urandom_range(3));
      end
    end
    return q;
  endfunction

  task automatic run_phase(input int unsigned cb, input int unsigned ae, input int unsigned ic,
                           input int unsigned snd_pct, input int unsigned rcv_pct,
                           input int unsigned alloc_pct, input bit wide_expand,
                           input int unsigned hold_cycles, input int unsigned count);
    program_cfg(cb, ae, ic);
    sender_idle_pct = snd_pct;
    stall_pct = rcv_pct;
    hold_order = hold_cycles;
    repeat (count) send_request(random_request(alloc_pct, wide_expand), 1'b0, '0);
  endtask

  // receiver side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_order != 0) begin
      hold_left = hold_order;
      hold_order = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data_o);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 16'(want.status), 16'(out_data_o.status));
        check_field("granted_index", 16'(want.granted_index), 16'(out_data_o.granted_index));
        check_field("in_use_count", 16'(want.in_use_count), 16'(out_data_o.in_use_count));
        check_field("capacity_now", 16'(want.capacity_now), 16'(out_data_o.capacity_now));
        check_field("capacity_clipped", 16'(want.capacity_clipped),
                    16'(out_data_o.capacity_clipped));
        checked_count++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("fixed_chunk_free_list_allocator regression: fail");
    $finish;
  end

  initial begin
    row_t directed_rows [$];

    // power-on registers: 64-byte chunks, no auto-expand, full pool
    directed_rows.push_back(typed_row(FUNC_ALLOC, 64, 0, ST_OK, 0, 1, 1024, 0));
    directed_rows.push_back(typed_row(FUNC_ALLOC, 65, 0, ST_TOO_LARGE, 0, 1, 1024, 0));
    directed_rows.push_back(typed_row(FUNC_ALLOC, 0, 0, ST_OK, 1, 2, 1024, 0));
    directed_rows.push_back(typed_row(FUNC_FREE, 0, 1023, ST_BAD_FREE, 0, 2, 1024, 0));
    directed_rows.push_back(typed_row(FUNC_FREE, 0, 1, ST_OK, 0, 1, 1024, 0));
    directed_rows.push_back(typed_row(FUNC_ALLOC, 65535, 0, ST_TOO_LARGE, 0, 1, 1024, 0));
    directed_rows.push_back(typed_row(FUNC_ALLOC, 8, 0, ST_OK, 1, 2, 1024, 0));
    directed_rows.push_back(typed_row(FUNC_FREE, 0, 0, ST_OK, 0, 1, 1024, 0));
    directed_rows.push_back(typed_row(FUNC_FREE, 0, 1, ST_OK, 0, 0, 1024, 0));
    directed_rows.push_back(typed_row(FUNC_FREE, 0, 0, ST_BAD_FREE, 0, 0, 1024, 0));
    directed_rows.push_back(typed_row(FUNC_UNUSED, 65535, 1023, ST_OK, 0, 0, 1024, 0));
    directed_rows.push_back(typed_row(FUNC_EXPAND, 0, 0, ST_ZERO_EXP, 0, 0, 1024, 0));
    // capacity shrinks below the chunks already issued
    directed_rows.push_back(cfg_row(8, 0, 1));
    directed_rows.push_back(typed_row(FUNC_ALLOC, 9, 0, ST_TOO_LARGE, 0, 0, 1, 0));
    directed_rows.push_back(typed_row(FUNC_ALLOC, 8, 0, ST_OK, 1, 1, 1, 0));
    directed_rows.push_back(typed_row(FUNC_ALLOC, 8, 0, ST_OK, 0, 2, 1, 0));
    directed_rows.push_back(typed_row(FUNC_ALLOC, 8, 0, ST_NO_CHUNK, 0, 2, 1, 0));
    directed_rows.push_back(typed_row(FUNC_EXPAND, 1, 0, ST_OK, 0, 2, 2, 0));
    directed_rows.push_back(typed_row(FUNC_ALLOC, 0, 0, ST_NO_CHUNK, 0, 2, 2, 0));
    // auto-expand by one on exhaustion
    directed_rows.push_back(cfg_row(65535, 1, 1));
    directed_rows.push_back(typed_row(FUNC_ALLOC, 65535, 0, ST_OK, 2, 3, 3, 0));
    directed_rows.push_back(req_row(FUNC_FREE, 0, 2));
    directed_rows.push_back(cfg_row(65535, 1024, 1024));
    directed_rows.push_back(typed_row(FUNC_EXPAND, 1, 0, ST_OK, 0, 2, 1024, 1));
    directed_rows.push_back(req_row(FUNC_ALLOC, 100, 0));
    directed_rows.push_back(cfg_row(64, 3, 2));
    directed_rows.push_back(req_row(FUNC_ALLOC, 64, 0));
    directed_rows.push_back(req_row(FUNC_ALLOC, 64, 0));
    directed_rows.push_back(req_row(FUNC_ALLOC, 64, 0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        program_cfg(directed_rows[i].cb, directed_rows[i].ae, directed_rows[i].ic);
      end else begin
        send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].known);
      end
    end

    // extra capacity only ever grows, so small pools come first and wide expands last
    run_phase(64, 0, 6, 0, 0, 55, 1'b0, 300, 235);
    run_phase(1000, 2, 10, 86, 0, 60, 1'b0, 0, 235);
    run_phase(200, 16, 1, 0, 86, 60, 1'b0, 0, 235);
    run_phase(8, 0, 1024, 38, 38, 80, 1'b0, 0, 235);
    run_phase(65535, 1024, 1, 0, 0, 55, 1'b1, 0, 235);
    run_phase(4096, 1, 1024, 38, 38, 50, 1'b1, 0, 235);

    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("sent %0d requests, checked %0d results: %0d grants, %0d bad frees",
             sent_count, checked_count, grant_count, bad_free_count);
    $display("pool exhausted %0d times, %0d clipped expansions, %0d chunks issued",
             starved_count, clipped_count, fresh_issued);
    if (fail_count == 0) begin
      $display("fixed_chunk_free_list_allocator regression: pass");
    end else begin
      $display("fixed_chunk_free_list_allocator regression: fail");
    end
    $finish;
  end

endmodule
